// ===== design/deq_pkg.sv =====
package deq_pkg;

  localparam int unsigned VAL_W = 32;

  // value shown as front and back while the queue is empty
  localparam logic [VAL_W-1:0] EMPTY_PEEK = '1;

  typedef enum logic [1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_PUSH_BACK  = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_POP_BACK   = 2'd3
  } deq_req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } deq_status_e;

  // one update of a chain of cells
  typedef struct packed {
    logic push_head;  // every cell takes its left neighbor, cell 0 the new value
    logic pop_head;   // every cell takes its right neighbor
    logic push_tail;  // the cell just past the last entry takes the new value
  } deq_cmd_t;

endpackage

// ===== design/deq_cell.sv =====
module deq_cell
  import deq_pkg::*;
(
  input  logic             clk_i,
  input  deq_cmd_t         cmd_i,
  input  logic             tail_sel_i,
  input  logic [VAL_W-1:0] new_val_i,
  input  logic [VAL_W-1:0] left_val_i,
  input  logic [VAL_W-1:0] right_val_i,
  output logic [VAL_W-1:0] val_o
);

  logic [VAL_W-1:0] val_q;
  logic [VAL_W-1:0] val_d;

  always_comb begin
    val_d = val_q;
    if (cmd_i.push_head) begin
      val_d = left_val_i;
    end else if (cmd_i.pop_head) begin
      val_d = right_val_i;
    end else if (cmd_i.push_tail && tail_sel_i) begin
      val_d = new_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

// ===== design/deq_chain.sv =====
module deq_chain
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  deq_cmd_t         cmd_i,
  input  logic [CNT_W-1:0] count_i,
  input  logic [VAL_W-1:0] new_val_i,
  output logic [VAL_W-1:0] head0_o,
  output logic [VAL_W-1:0] head1_o
);

  logic [VAL_W-1:0] val_w [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VAL_W-1:0] left_w;
    logic [VAL_W-1:0] right_w;
    logic             tail_sel_w;

    if (i == 0) begin : g_first
      assign left_w = new_val_i;
    end else begin : g_mid
      assign left_w = val_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_inner
      assign right_w = val_w[i+1];
    end

    assign tail_sel_w = (count_i == CNT_W'(i));

    deq_cell u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd_i),
      .tail_sel_i  (tail_sel_w),
      .new_val_i   (new_val_i),
      .left_val_i  (left_w),
      .right_val_i (right_w),
      .val_o       (val_w[i])
    );
  end

  assign head0_o = val_w[0];
  assign head1_o = val_w[1];

endmodule

// ===== design/double_ended_queue.sv =====
// bounded double-ended queue of signed 32-bit values
//
// input channel (s_axis): tuser carries the request kind (push front, push
// back, pop front, pop back), tdata the value to push; pops ignore tdata
// output channel (m_axis): one transfer per request; tuser carries the
// status (ok, underflow, overflow), tdata the popped value, the front and
// back entries after the request (-1 when empty) and the entry count
//
// latency: the result is valid in the cycle after the request transfer
// throughput: one request per cycle while no result is stalled; all cells that a
// request changes in the two chains update together, so the cell update sets the rate
// stall: the result sits in the output register while m_axis_tready is low,
// and s_axis_tready drops until it is taken
// reset: the queue is empty and no result is pending; entries hold no reset
// value, but only written entries are ever shown
module double_ended_queue
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1),
  localparam int unsigned OUT_BITS = 3 * VAL_W + CNT_W,
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [VAL_W-1:0]      s_axis_tdata,   // push_value
  input  logic [1:0]            s_axis_tuser,   // req_type
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // popped_value, front_value,
                                                // back_value, entry_count
  output logic [1:0]            m_axis_tuser    // status
);

  // two chains hold the same entries: the front chain keeps the front entry
  // in cell 0, the back chain keeps them reversed with the back entry in
  // cell 0, so both ends and their neighbors sit at fixed cells
  logic [CNT_W-1:0] count_q, count_d;
  logic             m_valid_q;
  deq_status_e      m_status_q;
  logic [VAL_W-1:0] m_popped_q, m_front_q, m_back_q;
  logic [CNT_W-1:0] m_count_q;

  logic             accept;
  logic             empty, full, one_left;
  deq_req_e         req;
  deq_cmd_t         front_cmd, back_cmd;
  deq_status_e      status;
  logic [VAL_W-1:0] popped, front_nxt, back_nxt;
  logic [VAL_W-1:0] fr0, fr1, bk0, bk1;

  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign req           = deq_req_e'(s_axis_tuser);
  assign empty         = (count_q == '0);
  assign full          = (count_q == CNT_W'(DEPTH));
  assign one_left      = (count_q == CNT_W'(1));

  always_comb begin
    front_cmd = '0;
    back_cmd  = '0;
    count_d   = count_q;
    status    = ST_OK;
    popped    = '0;
    // unchanged queue by default
    front_nxt = empty ? EMPTY_PEEK : fr0;
    back_nxt  = empty ? EMPTY_PEEK : bk0;
    case (req)
      REQ_PUSH_FRONT: begin
        if (full) begin
          status = ST_OVERFLOW;
        end else begin
          front_cmd.push_head = accept;
          back_cmd.push_tail  = accept;
          count_d             = count_q + CNT_W'(1);
          front_nxt           = s_axis_tdata;
          if (empty) back_nxt = s_axis_tdata;
        end
      end
      REQ_PUSH_BACK: begin
        if (full) begin
          status = ST_OVERFLOW;
        end else begin
          back_cmd.push_head   = accept;
          front_cmd.push_tail  = accept;
          count_d              = count_q + CNT_W'(1);
          back_nxt             = s_axis_tdata;
          if (empty) front_nxt = s_axis_tdata;
        end
      end
      REQ_POP_FRONT: begin
        if (empty) begin
          status = ST_UNDERFLOW;
        end else begin
          front_cmd.pop_head = accept;
          count_d            = count_q - CNT_W'(1);
          popped             = fr0;
          front_nxt          = one_left ? EMPTY_PEEK : fr1;
          back_nxt           = one_left ? EMPTY_PEEK : bk0;
        end
      end
      REQ_POP_BACK: begin
        if (empty) begin
          status = ST_UNDERFLOW;
        end else begin
          back_cmd.pop_head = accept;
          count_d           = count_q - CNT_W'(1);
          popped            = bk0;
          back_nxt          = one_left ? EMPTY_PEEK : bk1;
          front_nxt         = one_left ? EMPTY_PEEK : fr0;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  deq_chain #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_front_chain (
    .clk_i     (clk_i),
    .cmd_i     (front_cmd),
    .count_i   (count_q),
    .new_val_i (s_axis_tdata),
    .head0_o   (fr0),
    .head1_o   (fr1)
  );

  deq_chain #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_back_chain (
    .clk_i     (clk_i),
    .cmd_i     (back_cmd),
    .count_i   (count_q),
    .new_val_i (s_axis_tdata),
    .head0_o   (bk0),
    .head1_o   (bk1)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (s_axis_tready) begin
        m_valid_q <= s_axis_tvalid;
      end
    end
  end

  // result payload, loaded on each request transfer
  always_ff @(posedge clk_i) begin
    if (accept) begin
      m_status_q <= status;
      m_popped_q <= popped;
      m_front_q  <= front_nxt;
      m_back_q   <= back_nxt;
      m_count_q  <= count_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tdata  = OUT_DATA_W'({m_count_q, m_back_q, m_front_q, m_popped_q});

endmodule

// ===== design/deq_checker.sv =====
module deq_checker
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1),
  localparam int unsigned OUT_DATA_W = ((3 * VAL_W + CNT_W + 7) / 8) * 8
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [1:0]            m_axis_tuser
);

  logic [VAL_W-1:0] front_w, back_w;
  logic [CNT_W-1:0] count_w;

  assign front_w = m_axis_tdata[2*VAL_W-1:VAL_W];
  assign back_w  = m_axis_tdata[3*VAL_W-1:2*VAL_W];
  assign count_w = m_axis_tdata[3*VAL_W+CNT_W-1:3*VAL_W];

  // a pending result is never dropped
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // a request transfer yields a result in the next cycle
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("no result after request");

  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> count_w <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && count_w == '0 |-> front_w == EMPTY_PEEK && back_w == EMPTY_PEEK)
    else $error("empty queue shows entries");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_OVERFLOW || m_axis_tuser == ST_UNDERFLOW)
    |-> (m_axis_tuser == ST_OVERFLOW && count_w == CNT_W'(DEPTH))
     || (m_axis_tuser == ST_UNDERFLOW && count_w == '0))
    else $error("error status with wrong count");

endmodule

bind double_ended_queue deq_checker #(.DEPTH(DEPTH)) u_deq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
